// File: rtl/motion_blur_pixel_blend_assert.svh
// Assertion macros for the motion blur pixel blend block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef MOTION_BLUR_PIXEL_BLEND_ASSERT_SVH
`define MOTION_BLUR_PIXEL_BLEND_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBPB_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("mbpb same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MBPB_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("mbpb next-cycle check failed");

`endif

// File: rtl/mbpb_pkg.sv
// Shared types and constants for the motion blur pixel blend block.
// Used by mbpb_lane, mbpb_merge and motion_blur_pixel_blend.
package mbpb_pkg;

    localparam int LANES    = 4;
    localparam int BYTE_W   = 8;
    localparam int PIXEL_W  = 32;
    localparam int WEIGHT_W = 9;
    localparam int SUM_W    = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 9'd256;
    localparam logic [SUM_W-1:0]    ROUND_HALF  = 16'd128;

    localparam logic MODE_GRAY      = 1'b0;
    localparam logic MODE_TRUECOLOR = 1'b1;

    localparam logic [8:0] RST_BLEND_WEIGHT = 9'd256;
    localparam logic       RST_PIXEL_MODE   = MODE_TRUECOLOR;
    localparam logic [2:0] RST_SKIP_BYTE    = 3'd3;
    localparam logic [7:0] RST_GRAY_LOW     = 8'd0;
    localparam logic [8:0] RST_GRAY_HIGH    = 9'd256;

    typedef enum logic [2:0] {
        REG_BLEND_WEIGHT = 3'd0,
        REG_PIXEL_MODE   = 3'd1,
        REG_SKIP_BYTE    = 3'd2,
        REG_GRAY_LOW     = 3'd3,
        REG_GRAY_HIGH    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic             valid;
        logic             gray_mode;
        logic [LANES-1:0] blend_mask;
    } ctrl_t;

endpackage

// File: rtl/mbpb_lane.sv
// One byte lane: weighted sum old*(256-n) + new*n, registered.
// Depends on mbpb_pkg.
module mbpb_lane
(
    input  logic                               clk,
    input  logic                               load,
    input  logic [mbpb_pkg::BYTE_W-1:0]        old_byte,
    input  logic [mbpb_pkg::BYTE_W-1:0]        new_byte,
    input  logic [mbpb_pkg::WEIGHT_W-1:0]      weight,
    input  logic [mbpb_pkg::WEIGHT_W-1:0]      inv_weight,
    output logic [mbpb_pkg::SUM_W-1:0]         sum
);

    localparam int PROD_W = mbpb_pkg::BYTE_W + mbpb_pkg::WEIGHT_W;

    logic [PROD_W-1:0]              prod_old;
    logic [PROD_W-1:0]              prod_new;
    logic [PROD_W-1:0]              prod_sum;
    logic [mbpb_pkg::SUM_W-1:0]     sum_reg;
    logic [mbpb_pkg::SUM_W-1:0]     sum_next;

    always_comb
    begin
        prod_old = PROD_W'(old_byte) * PROD_W'(inv_weight);
        prod_new = PROD_W'(new_byte) * PROD_W'(weight);
        prod_sum = prod_old + prod_new;
        sum_next = prod_sum[mbpb_pkg::SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// File: rtl/mbpb_merge.sv
// Merge stage: picks lane results, applies gray rounding, range and nudge.
// Depends on mbpb_pkg; fed by the mbpb_lane sums.
module mbpb_merge
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  mbpb_pkg::ctrl_t                               ctrl,
    input  logic [mbpb_pkg::LANES-1:0][mbpb_pkg::SUM_W-1:0] lane_sum,
    input  logic [mbpb_pkg::PIXEL_W-1:0]                  old_pixel,
    input  logic [mbpb_pkg::BYTE_W-1:0]                   new_gray,
    input  logic [7:0]                                    gray_low,
    input  logic [8:0]                                    gray_high,
    output logic                                          done,
    output logic [mbpb_pkg::PIXEL_W-1:0]                  blended_pixel
);

    localparam int BW = mbpb_pkg::BYTE_W;

    logic [mbpb_pkg::PIXEL_W-1:0] color_pixel;
    logic [mbpb_pkg::SUM_W-1:0]   gray_sum;
    logic [BW-1:0]                old_gray;
    logic [BW-1:0]                gray_round;
    logic [BW-1:0]                gray_byte;
    logic                         gray_in_range;
    logic [mbpb_pkg::PIXEL_W-1:0] pixel_next;
    logic                         done_reg;
    logic [mbpb_pkg::PIXEL_W-1:0] pixel_reg;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_byte
            if (g < mbpb_pkg::LANES)
            begin : g_lane
                assign color_pixel[BW*g +: BW] = ctrl.blend_mask[g] ?
                    lane_sum[g][mbpb_pkg::SUM_W-1 -: BW] : old_pixel[BW*g +: BW];
            end
            else
            begin : g_pass
                assign color_pixel[BW*g +: BW] = old_pixel[BW*g +: BW];
            end
        end
    endgenerate

    always_comb
    begin
        old_gray      = old_pixel[BW-1:0];
        gray_sum      = lane_sum[0] + mbpb_pkg::ROUND_HALF;
        gray_round    = gray_sum[mbpb_pkg::SUM_W-1 -: BW];
        gray_in_range = (old_gray >= gray_low) && ({1'b0, old_gray} < gray_high) &&
                        (new_gray >= gray_low) && ({1'b0, new_gray} < gray_high);
        gray_byte     = gray_round;
        if (!gray_in_range)
        begin
            gray_byte = old_gray;
        end
        else if ((gray_round == old_gray) && (old_gray != new_gray))
        begin
            gray_byte = (old_gray < new_gray) ? gray_round + 8'd1 : gray_round - 8'd1;
        end
        pixel_next = ctrl.gray_mode ? {{(mbpb_pkg::PIXEL_W-BW){1'b0}}, gray_byte}
                                    : color_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign done          = done_reg;
    assign blended_pixel = pixel_reg;

endmodule

// File: rtl/motion_blur_pixel_blend.sv
// Motion blur pixel blend: one pixel per clock, busy is never raised.
// Registers: lane sums and ctrl_reg, then the merge registers for blended_pixel and done.
// Throughput: one transfer per cycle, set by the per-lane multiply-add and the merge register.
// Reset: rst_n is asynchronous, active low; clears the pipeline valids and loads register defaults.
// Results cannot be stalled; each one is shown for exactly one cycle.
// Depends on mbpb_pkg, mbpb_lane, mbpb_merge and motion_blur_pixel_blend_assert.svh.
`include "motion_blur_pixel_blend_assert.svh"

module motion_blur_pixel_blend
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbpb_pkg::ADDR_W-1:0]       paddr,
    input  logic [mbpb_pkg::DATA_W-1:0]       pwdata,
    output logic [mbpb_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [mbpb_pkg::PIXEL_W-1:0]      new_pixel,
    input  logic [mbpb_pkg::PIXEL_W-1:0]      old_pixel,
    output logic                              done,
    output logic [mbpb_pkg::PIXEL_W-1:0]      blended_pixel
);

    localparam int LANES = mbpb_pkg::LANES;

    logic [8:0]                                 blend_weight_reg;
    logic                                       pixel_mode_reg;
    logic [2:0]                                 skip_byte_reg;
    logic [7:0]                                 gray_low_reg;
    logic [8:0]                                 gray_high_reg;
    mbpb_pkg::reg_index_t                       reg_index;
    logic                                       cfg_write;
    logic                                       accept;
    logic [mbpb_pkg::WEIGHT_W-1:0]              weight_sat;
    logic [mbpb_pkg::WEIGHT_W-1:0]              inv_weight;
    mbpb_pkg::ctrl_t                            ctrl_reg;
    mbpb_pkg::ctrl_t                            ctrl_next;
    logic [mbpb_pkg::PIXEL_W-1:0]               old_pixel_reg;
    logic [mbpb_pkg::BYTE_W-1:0]                new_gray_reg;
    logic [LANES-1:0][mbpb_pkg::SUM_W-1:0]      lane_sum;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign reg_index = mbpb_pkg::reg_index_t'(paddr[mbpb_pkg::ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg <= mbpb_pkg::RST_BLEND_WEIGHT;
            pixel_mode_reg   <= mbpb_pkg::RST_PIXEL_MODE;
            skip_byte_reg    <= mbpb_pkg::RST_SKIP_BYTE;
            gray_low_reg     <= mbpb_pkg::RST_GRAY_LOW;
            gray_high_reg    <= mbpb_pkg::RST_GRAY_HIGH;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                mbpb_pkg::REG_BLEND_WEIGHT: blend_weight_reg <= pwdata[8:0];
                mbpb_pkg::REG_PIXEL_MODE:   pixel_mode_reg   <= pwdata[0];
                mbpb_pkg::REG_SKIP_BYTE:    skip_byte_reg    <= pwdata[2:0];
                mbpb_pkg::REG_GRAY_LOW:     gray_low_reg     <= pwdata[7:0];
                mbpb_pkg::REG_GRAY_HIGH:    gray_high_reg    <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            mbpb_pkg::REG_BLEND_WEIGHT: prdata = {23'd0, blend_weight_reg};
            mbpb_pkg::REG_PIXEL_MODE:   prdata = {31'd0, pixel_mode_reg};
            mbpb_pkg::REG_SKIP_BYTE:    prdata = {29'd0, skip_byte_reg};
            mbpb_pkg::REG_GRAY_LOW:     prdata = {24'd0, gray_low_reg};
            mbpb_pkg::REG_GRAY_HIGH:    prdata = {23'd0, gray_high_reg};
            default:                    prdata = '0;
        endcase
    end

    // Clamp the weight and build the lane controls
    always_comb
    begin
        weight_sat = (blend_weight_reg > mbpb_pkg::FULL_WEIGHT) ? mbpb_pkg::FULL_WEIGHT
                                                                : blend_weight_reg;
        inv_weight = mbpb_pkg::FULL_WEIGHT - weight_sat;
        ctrl_next.valid     = accept;
        ctrl_next.gray_mode = (pixel_mode_reg == mbpb_pkg::MODE_GRAY);
        for (int i = 0; i < LANES; i++)
        begin
            ctrl_next.blend_mask[i] = (skip_byte_reg != 3'(i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_pixel_reg <= old_pixel;
            new_gray_reg  <= new_pixel[mbpb_pkg::BYTE_W-1:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            mbpb_lane u_lane
            (
                .clk        (clk),
                .load       (accept),
                .old_byte   (old_pixel[mbpb_pkg::BYTE_W*g +: mbpb_pkg::BYTE_W]),
                .new_byte   (new_pixel[mbpb_pkg::BYTE_W*g +: mbpb_pkg::BYTE_W]),
                .weight     (weight_sat),
                .inv_weight (inv_weight),
                .sum        (lane_sum[g])
            );
        end
    endgenerate

    mbpb_merge u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_reg),
        .lane_sum      (lane_sum),
        .old_pixel     (old_pixel_reg),
        .new_gray      (new_gray_reg),
        .gray_low      (gray_low_reg),
        .gray_high     (gray_high_reg),
        .done          (done),
        .blended_pixel (blended_pixel)
    );

    `MBPB_ASSERT_NEXT(a_accept_to_stage, start && !busy, ctrl_reg.valid)
    `MBPB_ASSERT_NEXT(a_stage_to_done, ctrl_reg.valid, done)
    `MBPB_ASSERT_NOW(a_done_has_source, done, $past(start, 2))
    `MBPB_ASSERT_NOW(a_gray_upper_zero, done && (pixel_mode_reg == mbpb_pkg::MODE_GRAY),
                     blended_pixel[31:8] == 24'd0)

endmodule
